[rtl/tfdt_pkg.sv]
// Package for the transport flow demultiplexing table: beat payload types,
// operation and status codes, controller states and the command/status bundles.
// No dependencies.
package tfdt_pkg;

    typedef enum logic [2:0] {
        OP_LOOKUP  = 3'd0,
        OP_ADD     = 3'd1,
        OP_ADD_EPH = 3'd2,
        OP_REMOVE  = 3'd3,
        OP_RESERVE = 3'd4,
        OP_RELEASE = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_IN_USE  = 3'd2,
        ST_NO_REC  = 3'd3,
        ST_NO_PORT = 3'd4,
        ST_FULL    = 3'd5
    } t_status;

    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [31:0] LOOPBACK_IP = 32'h7F00_0001;
    // Ephemeral ports are 49152..65535: two set top bits and a 14-bit index.
    localparam int          EPH_BITS    = 14;
    localparam logic [1:0]  EPH_TOP     = 2'b11;
    localparam logic [15:0] CNT_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  operation;
        logic        match_kind;
        logic [7:0]  protocol;
        logic [31:0] local_ip;
        logic [15:0] local_port;
        logic [31:0] remote_ip;
        logic [15:0] remote_port;
        logic        option;
        logic [5:0]  handle;
        logic [15:0] port_offset;
        logic        header_complete;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic        hit;
        logic [5:0]  result_handle;
        logic [15:0] chosen_port;
        logic [31:0] chosen_ip;
    } t_out;

    typedef struct packed {
        logic        kind;
        logic [7:0]  proto;
        logic [31:0] lip;
        logic [15:0] lport;
        logic [31:0] rip;
        logic [15:0] rport;
    } t_flow_key;

    typedef struct packed {
        logic        valid;
        logic [7:0]  proto;
        logic [31:0] ip;
        logic [15:0] port;
        logic [15:0] active;
        logic [15:0] reserved;
        logic        reuse;
    } t_prec;

    typedef enum logic [2:0] {
        PU_NONE,
        PU_ADD_RES,
        PU_ADD,
        PU_CREATE_ADD,
        PU_RESERVE,
        PU_CREATE_RES,
        PU_REMOVE,
        PU_RELEASE
    } t_pupd;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_FSCAN,
        S_FWAIT,
        S_FCHK,
        S_PSCAN,
        S_PWAIT,
        S_PCHK,
        S_PRD,
        S_PRWAIT,
        S_PRCHK,
        S_FRD,
        S_FRWAIT,
        S_NEXT,
        S_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    load;
        logic    fscan;
        logic    pscan;
        logic    rd_flow;
        logic    rd_port_handle;
        logic    rd_port_rec;
        logic    flow_new;
        logic    flow_kill;
        t_pupd   pupd;
        logic    eph_first;
        logic    eph_next;
        logic    out_load;
        logic    out_blank;
        t_status out_status;
    } t_dp_cmd;

    typedef struct packed {
        logic       clr_busy;
        logic       fbusy;
        logic       pbusy;
        logic [2:0] op;
        logic       proto_ok;
        logic       lport_zero;
        logic       option;
        logic       handle_fe_ok;
        logic       handle_pr_ok;
        logic       ip_bad;
        logic       found5;
        logic       found3;
        logic       dup;
        logic       ffree;
        logic       fent_valid;
        logic       pm_found;
        logic       pfree;
        logic       rec_valid;
        logic       rec_key_eq;
        logic       rec_act0;
        logic       rec_res0;
        logic       rec_reuse;
        logic       eph_last;
        logic       out_busy;
    } t_dp_stat;

endpackage

[rtl/tfdt_ctrl.sv]
// Controller state machine for the flow table: sequences scans, record reads,
// writes and the result beat. Depends on tfdt_pkg.
module tfdt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tfdt_pkg::t_dp_stat i_stat,
    output tfdt_pkg::t_dp_cmd  o_cmd
);
    import tfdt_pkg::*;

    t_state  r_state, n_state;
    t_status r_st, n_st;
    logic    r_blank, n_blank;
    t_pupd   r_pupd, n_pupd;
    logic    r_eph, n_eph;
    t_op     op;

    assign op = t_op'(i_stat.op);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_st    <= ST_OK;
            r_blank <= 1'b1;
            r_pupd  <= PU_NONE;
            r_eph   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
            r_blank <= n_blank;
            r_pupd  <= n_pupd;
            r_eph   <= n_eph;
        end
    end

    always_comb begin
        n_state = r_state;
        n_st    = r_st;
        n_blank = r_blank;
        n_pupd  = r_pupd;
        n_eph   = r_eph;
        unique case (r_state)
            S_CLEAR: if (!i_stat.clr_busy) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_DECODE;
            S_DECODE: begin
                n_st    = ST_OK;
                n_blank = 1'b0;
                n_pupd  = PU_NONE;
                n_eph   = (op == OP_ADD_EPH) || (op == OP_RESERVE && i_stat.lport_zero);
                unique case (op)
                    OP_LOOKUP: begin
                        if (i_stat.proto_ok) begin
                            n_state = S_FSCAN;
                        end else begin
                            n_state = S_DONE;
                            n_blank = 1'b1;
                        end
                    end
                    OP_ADD: begin
                        if (i_stat.lport_zero) begin
                            n_state = S_DONE;
                            n_st    = ST_INVALID;
                        end else begin
                            n_state = S_FSCAN;
                        end
                    end
                    OP_ADD_EPH: n_state = S_FSCAN;
                    OP_REMOVE: begin
                        if (!i_stat.handle_fe_ok) begin
                            n_state = S_DONE;
                            n_st    = ST_INVALID;
                        end else begin
                            n_state = S_FRD;
                        end
                    end
                    OP_RESERVE: begin
                        if (i_stat.ip_bad) begin
                            n_state = S_DONE;
                            n_st    = ST_INVALID;
                        end else begin
                            n_state = S_PSCAN;
                        end
                    end
                    OP_RELEASE: begin
                        if (!i_stat.handle_pr_ok) begin
                            n_state = S_DONE;
                            n_st    = ST_NO_REC;
                        end else begin
                            n_state = S_PRD;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                        n_st    = ST_INVALID;
                    end
                endcase
            end
            S_FSCAN: n_state = S_FWAIT;
            S_FWAIT: if (!i_stat.fbusy) n_state = S_FCHK;
            S_FCHK: begin
                if (op == OP_LOOKUP) begin
                    n_state = S_DONE;
                    n_blank = !(i_stat.found5 || i_stat.found3);
                end else if (r_eph) begin
                    if (!i_stat.ffree) begin
                        n_state = S_DONE;
                        n_st    = ST_FULL;
                    end else if (i_stat.dup) begin
                        n_state = S_NEXT;
                    end else begin
                        n_state = S_PSCAN;
                    end
                end else if (i_stat.dup) begin
                    n_state = S_DONE;
                    n_st    = ST_IN_USE;
                end else if (!i_stat.ffree) begin
                    n_state = S_DONE;
                    n_st    = ST_FULL;
                end else if (i_stat.option) begin
                    if (!i_stat.handle_pr_ok) begin
                        n_state = S_DONE;
                        n_st    = ST_NO_REC;
                    end else begin
                        n_state = S_PRD;
                    end
                end else begin
                    n_state = S_PSCAN;
                end
            end
            S_PSCAN: n_state = S_PWAIT;
            S_PWAIT: if (!i_stat.pbusy) n_state = S_PCHK;
            S_PCHK: begin
                if (op == OP_RESERVE) begin
                    if (i_stat.pm_found) begin
                        if ((!i_stat.rec_act0 || !i_stat.rec_res0) && !i_stat.rec_reuse) begin
                            if (r_eph) begin
                                n_state = S_NEXT;
                            end else begin
                                n_state = S_DONE;
                                n_st    = ST_IN_USE;
                            end
                        end else begin
                            n_state = S_WRITE;
                            n_pupd  = PU_RESERVE;
                        end
                    end else if (!i_stat.pfree) begin
                        n_state = S_DONE;
                        n_st    = ST_NO_REC;
                    end else begin
                        n_state = S_WRITE;
                        n_pupd  = PU_CREATE_RES;
                    end
                end else begin
                    if (i_stat.pm_found) begin
                        if (i_stat.rec_act0 && !i_stat.rec_res0 && !i_stat.rec_reuse) begin
                            if (r_eph) begin
                                n_state = S_NEXT;
                            end else begin
                                n_state = S_DONE;
                                n_st    = ST_IN_USE;
                            end
                        end else begin
                            n_state = S_WRITE;
                            n_pupd  = PU_ADD;
                        end
                    end else if (!i_stat.pfree) begin
                        if (r_eph) begin
                            n_state = S_NEXT;
                        end else begin
                            n_state = S_DONE;
                            n_st    = ST_NO_REC;
                        end
                    end else begin
                        n_state = S_WRITE;
                        n_pupd  = PU_CREATE_ADD;
                    end
                end
            end
            S_PRD:    n_state = S_PRWAIT;
            S_PRWAIT: n_state = S_PRCHK;
            S_PRCHK: begin
                if (op == OP_REMOVE) begin
                    if (i_stat.rec_valid) begin
                        n_state = S_WRITE;
                        n_pupd  = PU_REMOVE;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (!i_stat.rec_valid) begin
                    n_state = S_DONE;
                    n_st    = ST_NO_REC;
                end else if (op == OP_RELEASE) begin
                    if (i_stat.rec_res0) begin
                        n_state = S_DONE;
                        n_st    = ST_INVALID;
                    end else begin
                        n_state = S_WRITE;
                        n_pupd  = PU_RELEASE;
                    end
                end else if (!i_stat.rec_key_eq) begin
                    n_state = S_DONE;
                    n_st    = ST_INVALID;
                end else begin
                    n_state = S_WRITE;
                    n_pupd  = PU_ADD_RES;
                end
            end
            S_FRD:    n_state = S_FRWAIT;
            S_FRWAIT: begin
                if (!i_stat.fent_valid) begin
                    n_state = S_DONE;
                    n_st    = ST_INVALID;
                end else begin
                    n_state = S_PRD;
                end
            end
            S_NEXT: begin
                if (i_stat.eph_last) begin
                    n_state = S_DONE;
                    n_st    = ST_NO_PORT;
                end else if (op == OP_RESERVE) begin
                    n_state = S_PSCAN;
                end else begin
                    n_state = S_FSCAN;
                end
            end
            S_WRITE: n_state = S_DONE;
            S_DONE:  if (!i_stat.out_busy) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.eph_first = (op == OP_ADD_EPH) ||
                                  (op == OP_RESERVE && i_stat.lport_zero);
            end
            S_FSCAN: o_cmd.fscan = 1'b1;
            S_PSCAN: o_cmd.pscan = 1'b1;
            S_PRD: begin
                o_cmd.rd_port_rec    = (op == OP_REMOVE);
                o_cmd.rd_port_handle = (op != OP_REMOVE);
            end
            S_FRD:    o_cmd.rd_flow = 1'b1;
            S_FRWAIT: o_cmd.flow_kill = i_stat.fent_valid;
            S_NEXT:   o_cmd.eph_next = !i_stat.eph_last;
            S_WRITE: begin
                o_cmd.pupd     = r_pupd;
                o_cmd.flow_new = (op == OP_ADD) || (op == OP_ADD_EPH);
            end
            S_DONE: begin
                o_cmd.out_load   = !i_stat.out_busy;
                o_cmd.out_status = r_st;
                o_cmd.out_blank  = r_blank;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

[rtl/tfdt_dp.sv]
// Datapath of the flow table: item and key registers, flow and port record
// memories with their scan engines, record update logic and result register.
// Depends on tfdt_pkg.
module tfdt_dp #(
    parameter int FLOW_ENTRIES = 64,
    parameter int PORT_RECORDS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tfdt_pkg::t_in      i_in_data,
    input  logic               i_cfg_valid,
    input  logic [31:0]        i_cfg_data,
    input  tfdt_pkg::t_dp_cmd  i_cmd,
    output tfdt_pkg::t_dp_stat o_stat,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output tfdt_pkg::t_out     o_out_data
);
    import tfdt_pkg::*;

    localparam int FW   = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int PW   = (PORT_RECORDS > 1) ? $clog2(PORT_RECORDS) : 1;
    localparam int KW   = $bits(t_flow_key);
    localparam int FEW  = 1 + KW + PW;
    localparam int MAXN = (FLOW_ENTRIES > PORT_RECORDS) ? FLOW_ENTRIES : PORT_RECORDS;
    localparam int CW   = $clog2(MAXN);

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == CNT_MAX) ? v : v + 16'd1;
    endfunction

    function automatic logic [15:0] floor_dec(input logic [15:0] v);
        return (v == 16'd0) ? v : v - 16'd1;
    endfunction

    // Item registers
    logic [31:0]         r_local_addr;
    logic [2:0]          r_op;
    logic                r_kind;
    logic [7:0]          r_proto;
    logic [31:0]         r_lip;
    logic [15:0]         r_lport;
    logic [31:0]         r_rip;
    logic [15:0]         r_rport;
    logic                r_option;
    logic [5:0]          r_handle;
    logic [EPH_BITS-1:0] r_off;
    logic                r_complete;
    logic [EPH_BITS-1:0] r_eph_i;
    logic [EPH_BITS-1:0] eph_i1;

    // Memories and read data
    logic [FEW-1:0] r_flow_mem [FLOW_ENTRIES];
    t_prec          r_port_mem [PORT_RECORDS];
    logic [FEW-1:0] r_frd;
    t_prec          r_prd;

    // Clearing pass
    logic          r_clr;
    logic [CW-1:0] r_ccnt;

    // Scan engines
    logic          r_fscan, r_fpend;
    logic [FW-1:0] r_fcnt, r_fpidx;
    logic          r_f5, r_f3, r_ffree;
    logic [FW-1:0] r_f5_idx, r_f3_idx, r_ffree_idx;
    logic          r_pscan, r_ppend, r_pdir;
    logic [PW-1:0] r_pcnt, r_ppidx;
    logic          r_pm, r_pfree;
    logic [PW-1:0] r_pfree_idx;
    t_prec         r_rec;
    logic [PW-1:0] r_rec_idx;

    // Result
    logic r_out_valid;
    t_out r_out_data, n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_addr <= '0;
        end else if (i_cfg_valid) begin
            r_local_addr <= i_cfg_data;
        end
    end

    assign eph_i1 = r_eph_i + 1'b1;

    // Lookups may swap the two sides; reserve resolves zero and loopback.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_in_data.operation;
            r_kind     <= i_in_data.match_kind;
            r_proto    <= i_in_data.protocol;
            r_option   <= i_in_data.option;
            r_handle   <= i_in_data.handle;
            r_off      <= i_in_data.port_offset[EPH_BITS-1:0];
            r_complete <= i_in_data.header_complete;
            if (i_in_data.operation == OP_LOOKUP && i_in_data.option) begin
                r_lip   <= i_in_data.remote_ip;
                r_lport <= i_in_data.remote_port;
                r_rip   <= i_in_data.local_ip;
                r_rport <= i_in_data.local_port;
            end else begin
                r_lport <= i_in_data.local_port;
                r_rip   <= i_in_data.remote_ip;
                r_rport <= i_in_data.remote_port;
                if (i_in_data.operation == OP_RESERVE &&
                    (i_in_data.local_ip == 32'd0 || i_in_data.local_ip == LOOPBACK_IP)) begin
                    r_lip <= r_local_addr;
                end else begin
                    r_lip <= i_in_data.local_ip;
                end
            end
        end else if (i_cmd.eph_first) begin
            r_eph_i <= '0;
            r_lport <= {EPH_TOP, r_off};
        end else if (i_cmd.eph_next) begin
            r_eph_i <= eph_i1;
            r_lport <= {EPH_TOP, eph_i1 + r_off};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= 1'b1;
            r_ccnt <= '0;
        end else if (r_clr) begin
            r_ccnt <= r_ccnt + 1'b1;
            if (r_ccnt == CW'(MAXN - 1)) r_clr <= 1'b0;
        end
    end

    // Flow entry decode of the registered read data
    logic      f_valid;
    t_flow_key f_key;
    logic      base_eq, full_eq, m5, m3;

    assign f_valid = r_frd[FEW-1];
    assign f_key   = t_flow_key'(r_frd[FEW-2 -: KW]);
    assign base_eq = f_key.proto == r_proto && f_key.lip == r_lip && f_key.lport == r_lport;
    assign full_eq = base_eq && f_key.rip == r_rip && f_key.rport == r_rport;
    assign m5      = f_valid && f_key.kind && full_eq;
    assign m3      = f_valid && !f_key.kind && base_eq;

    // Port record update
    logic          create;
    logic [PW-1:0] wr_idx;
    t_prec         fresh, n_rec;
    t_flow_key     cur_key;

    assign create = (i_cmd.pupd == PU_CREATE_ADD) || (i_cmd.pupd == PU_CREATE_RES);
    assign wr_idx = create ? r_pfree_idx : r_rec_idx;
    assign cur_key = '{kind: r_kind, proto: r_proto, lip: r_lip, lport: r_lport,
                       rip: r_rip, rport: r_rport};

    always_comb begin
        fresh          = '0;
        fresh.valid    = 1'b1;
        fresh.proto    = r_proto;
        fresh.ip       = r_lip;
        fresh.port     = r_lport;
        n_rec          = r_rec;
        unique case (i_cmd.pupd)
            PU_ADD_RES: begin
                n_rec.reserved = floor_dec(r_rec.reserved);
                n_rec.active   = sat_inc(r_rec.active);
            end
            PU_ADD:        n_rec.active = sat_inc(r_rec.active);
            PU_CREATE_ADD: begin
                n_rec        = fresh;
                n_rec.active = 16'd1;
            end
            PU_RESERVE: begin
                if (r_rec.active == 16'd0 && r_rec.reserved == 16'd0) n_rec.reuse = r_option;
                n_rec.reserved = sat_inc(r_rec.reserved);
            end
            PU_CREATE_RES: begin
                n_rec          = fresh;
                n_rec.reuse    = r_option;
                n_rec.reserved = 16'd1;
            end
            PU_REMOVE: begin
                n_rec.active = floor_dec(r_rec.active);
                if (n_rec.active == 16'd0 && r_rec.reserved == 16'd0) n_rec.valid = 1'b0;
            end
            PU_RELEASE: begin
                n_rec.reserved = r_rec.reserved - 16'd1;
                if (r_rec.active == 16'd0 && n_rec.reserved == 16'd0) n_rec.valid = 1'b0;
            end
            default: n_rec = r_rec;
        endcase
    end

    // Flow memory: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            if ({1'b0, r_ccnt} < (CW + 1)'(FLOW_ENTRIES)) r_flow_mem[r_ccnt[FW-1:0]] <= '0;
        end else if (i_cmd.flow_new) begin
            r_flow_mem[r_ffree_idx] <= {1'b1, cur_key, wr_idx};
        end else if (i_cmd.flow_kill) begin
            r_flow_mem[FW'(r_handle)] <= {1'b0, r_frd[FEW-2:0]};
        end
        if (i_cmd.rd_flow) begin
            r_frd <= r_flow_mem[FW'(r_handle)];
        end else if (r_fscan) begin
            r_frd <= r_flow_mem[r_fcnt];
        end
    end

    // Port record memory
    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            if ({1'b0, r_ccnt} < (CW + 1)'(PORT_RECORDS)) r_port_mem[r_ccnt[PW-1:0]] <= '0;
        end else if (i_cmd.pupd != PU_NONE) begin
            r_port_mem[wr_idx] <= n_rec;
        end
        if (i_cmd.rd_port_handle) begin
            r_prd <= r_port_mem[PW'(r_handle)];
        end else if (i_cmd.rd_port_rec) begin
            r_prd <= r_port_mem[r_frd[PW-1:0]];
        end else if (r_pscan) begin
            r_prd <= r_port_mem[r_pcnt];
        end
    end

    // Flow scan: lowest index wins for each kind of match and for the free slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fscan <= 1'b0;
            r_fpend <= 1'b0;
        end else begin
            r_fpend <= r_fscan;
            if (i_cmd.fscan) begin
                r_fscan <= 1'b1;
            end else if (r_fscan && r_fcnt == FW'(FLOW_ENTRIES - 1)) begin
                r_fscan <= 1'b0;
            end
        end
        if (i_cmd.fscan) begin
            r_fcnt  <= '0;
            r_f5    <= 1'b0;
            r_f3    <= 1'b0;
            r_ffree <= 1'b0;
        end else begin
            if (r_fscan) r_fcnt <= r_fcnt + 1'b1;
            if (r_fpend) begin
                if (m5 && !r_f5) begin
                    r_f5     <= 1'b1;
                    r_f5_idx <= r_fpidx;
                end
                if (m3 && !r_f3) begin
                    r_f3     <= 1'b1;
                    r_f3_idx <= r_fpidx;
                end
                if (!f_valid && !r_ffree) begin
                    r_ffree     <= 1'b1;
                    r_ffree_idx <= r_fpidx;
                end
            end
        end
        r_fpidx <= r_fcnt;
    end

    // Port scan, and capture of directly read records.
    logic pmatch;
    assign pmatch = r_prd.valid && r_prd.proto == r_proto && r_prd.ip == r_lip &&
                    r_prd.port == r_lport;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pscan <= 1'b0;
            r_ppend <= 1'b0;
            r_pdir  <= 1'b0;
        end else begin
            r_ppend <= r_pscan;
            r_pdir  <= i_cmd.rd_port_handle | i_cmd.rd_port_rec;
            if (i_cmd.pscan) begin
                r_pscan <= 1'b1;
            end else if (r_pscan && r_pcnt == PW'(PORT_RECORDS - 1)) begin
                r_pscan <= 1'b0;
            end
        end
        r_ppidx <= r_pcnt;
        if (i_cmd.pscan) begin
            r_pcnt  <= '0;
            r_pm    <= 1'b0;
            r_pfree <= 1'b0;
        end else begin
            if (r_pscan) r_pcnt <= r_pcnt + 1'b1;
            if (r_ppend) begin
                if (pmatch && !r_pm) begin
                    r_pm      <= 1'b1;
                    r_rec     <= r_prd;
                    r_rec_idx <= r_ppidx;
                end
                if (!r_prd.valid && !r_pfree) begin
                    r_pfree     <= 1'b1;
                    r_pfree_idx <= r_ppidx;
                end
            end
        end
        if (r_pdir) r_rec <= r_prd;
        if (i_cmd.rd_port_handle) begin
            r_rec_idx <= PW'(r_handle);
        end else if (i_cmd.rd_port_rec) begin
            r_rec_idx <= r_frd[PW-1:0];
        end else if (i_cmd.pupd != PU_NONE) begin
            r_rec_idx <= wr_idx;
        end
    end

    // Result register
    always_comb begin
        n_out        = '0;
        n_out.status = i_cmd.out_status;
        if (i_cmd.out_status == ST_OK && !i_cmd.out_blank) begin
            unique case (t_op'(r_op))
                OP_LOOKUP: begin
                    n_out.hit           = 1'b1;
                    n_out.result_handle = r_f5 ? 6'(r_f5_idx) : 6'(r_f3_idx);
                    n_out.chosen_port   = r_lport;
                    n_out.chosen_ip     = r_lip;
                end
                OP_ADD, OP_ADD_EPH: begin
                    n_out.result_handle = 6'(r_ffree_idx);
                    n_out.chosen_port   = r_lport;
                    n_out.chosen_ip     = r_lip;
                end
                OP_REMOVE: begin
                    n_out.result_handle = r_handle;
                    n_out.chosen_port   = f_key.lport;
                    n_out.chosen_ip     = f_key.lip;
                end
                OP_RESERVE: begin
                    n_out.result_handle = 6'(r_rec_idx);
                    n_out.chosen_port   = r_lport;
                    n_out.chosen_ip     = r_lip;
                end
                OP_RELEASE: begin
                    n_out.result_handle = r_handle;
                    n_out.chosen_port   = r_rec.port;
                    n_out.chosen_ip     = r_rec.ip;
                end
                default: n_out = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) r_out_data <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        o_stat              = '0;
        o_stat.clr_busy     = r_clr;
        o_stat.fbusy        = r_fscan | r_fpend;
        o_stat.pbusy        = r_pscan | r_ppend;
        o_stat.op           = r_op;
        o_stat.proto_ok     = (r_proto == PROTO_TCP || r_proto == PROTO_UDP) && r_complete;
        o_stat.lport_zero   = (r_lport == 16'd0);
        o_stat.option       = r_option;
        o_stat.handle_fe_ok = 32'(r_handle) < 32'(FLOW_ENTRIES);
        o_stat.handle_pr_ok = 32'(r_handle) < 32'(PORT_RECORDS);
        o_stat.ip_bad       = (r_lip != r_local_addr);
        o_stat.found5       = r_f5;
        o_stat.found3       = r_f3;
        o_stat.dup          = r_kind ? r_f5 : r_f3;
        o_stat.ffree        = r_ffree;
        o_stat.fent_valid   = f_valid;
        o_stat.pm_found     = r_pm;
        o_stat.pfree        = r_pfree;
        o_stat.rec_valid    = r_rec.valid;
        o_stat.rec_key_eq   = r_rec.proto == r_proto && r_rec.ip == r_lip &&
                              r_rec.port == r_lport;
        o_stat.rec_act0     = (r_rec.active == 16'd0);
        o_stat.rec_res0     = (r_rec.reserved == 16'd0);
        o_stat.rec_reuse    = r_rec.reuse;
        o_stat.eph_last     = &r_eph_i;
        o_stat.out_busy     = r_out_valid && !i_out_ready;
    end

endmodule

[rtl/transport_flow_demux_table_unit.sv]
// A lookup's time is set by the flow scan reading one entry a cycle; an add
// runs a flow scan and then a port scan or, with the option set, a record read.
// Ephemeral searches repeat the scans per tried port: up to 16384 tries.
// One item is in work at a time; the next is taken in the cycle after the
// result is loaded. After reset a clearing pass runs over both stores.
module transport_flow_demux_table_unit #(
    parameter int FLOW_ENTRIES = 64,
    parameter int PORT_RECORDS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tfdt_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tfdt_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [31:0]    i_cfg_data
);
    import tfdt_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    tfdt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tfdt_dp #(
        .FLOW_ENTRIES (FLOW_ENTRIES),
        .PORT_RECORDS (PORT_RECORDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // No beat is taken while the stores are still being cleared.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.clr_busy |-> !o_in_ready)
        else $error("input taken during clearing pass");

    // Only one item is in work at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while one is in work");

    // The two scan engines never run together.
    a_scans_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(stat.fbusy && stat.pbusy))
        else $error("flow and port scans overlap");

    // A hit is only ever reported with a clean status.
    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.hit) |-> (o_out_data.status == ST_OK))
        else $error("hit reported with failing status");

endmodule
